// File: src/hfgf_pkg.sv
// Shared widths, constants, types and helpers for the hex face metric pipeline.
package hfgf_pkg;

    localparam int unsigned D_W     = 32;   // input derivative width
    localparam int unsigned WT_W    = 18;   // quadrature weight width
    localparam int unsigned FACE_W  = 3;
    localparam int unsigned PROD_W  = 64;
    localparam int unsigned COF_W   = 65;
    localparam int unsigned J_W     = 97;   // determinant, Q48.48
    localparam int unsigned MAG_W   = 48;   // |selected cofactor| in Q.16
    localparam int unsigned HALF_W  = 24;
    localparam int unsigned SQ_W    = 96;   // sum of squares
    localparam int unsigned LEN_W   = 48;   // normal length
    localparam int unsigned REM_W   = 50;   // root remainder
    localparam int unsigned CHK_W   = 25;   // |J| chunk for the corner weight product
    localparam int unsigned CHK_N   = 4;
    localparam int unsigned CWP_W   = CHK_W + WT_W;
    localparam int unsigned D2_W    = 115;  // |J| * corner weight
    localparam int unsigned Q_W     = 31;   // quotient bits below saturation
    localparam int unsigned NQ_W    = 17;   // normal quotient bits
    localparam int unsigned NRM_W   = 18;
    localparam int unsigned OUT_W   = 32;
    localparam int unsigned PL_W    = HALF_W + WT_W;
    localparam int unsigned LW_W    = 66;
    localparam int unsigned LW_CH   = 22;
    localparam int unsigned PP_W    = LW_CH + WT_W;
    localparam int unsigned WS_SUM_W = 84;
    localparam int unsigned WS_W    = WS_SUM_W - 32;

    localparam int unsigned FRONT_N  = 7;
    localparam int unsigned SQ_STEPS = LEN_W;
    localparam int unsigned BK_STEPS = Q_W;
    localparam int unsigned LAT      = FRONT_N + SQ_STEPS + 1 + BK_STEPS + 1;

    localparam logic [WT_W-1:0] CW_RESET = WT_W'(65536);

    localparam int unsigned IN_TDATA_W  = 328;
    localparam int unsigned OUT_TDATA_W = 216;

    // face codes
    localparam logic [FACE_W-1:0] FACE_NEG_T = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_S = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_R = 3'd2;
    localparam logic [FACE_W-1:0] FACE_POS_S = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NEG_R = 3'd4;
    localparam logic [FACE_W-1:0] FACE_POS_T = 3'd5;

    // operand pairs of the 18 cofactor products; inputs ordered
    // xr xs xt yr ys yt zr zs zt, even entry is the plus term
    localparam int unsigned CO_A [18] = '{4, 7, 7, 1, 1, 4, 6, 3, 0, 6, 3, 0, 3, 6, 6, 0, 0, 3};
    localparam int unsigned CO_B [18] = '{8, 5, 2, 8, 5, 2, 5, 8, 8, 2, 2, 5, 7, 4, 1, 7, 4, 1};

    typedef struct packed {
        logic                         fbad;
        logic                         fneg;
        logic [2:0]                   csgn;
        logic [2:0][MAG_W-1:0]        mag;
        logic [WT_W-1:0]              wa;
        logic [WT_W-1:0]              wb;
    } t_node;

    typedef struct packed {
        t_node              nd;
        logic               jneg;
        logic               jzero;
        logic [J_W-1:0]     jabs;
        logic [D2_W-1:0]    d2;
        logic               ovf_inv;
        logic               ovf_w;
        logic [SQ_W-1:0]    n;
        logic [LEN_W-1:0]   root;
        logic [REM_W-1:0]   rem;
        logic [J_W-1:0]     ri;
        logic [Q_W-1:0]     qi;
        logic [D2_W-1:0]    rw;
        logic [Q_W-1:0]     qw;
    } t_mid;

    typedef struct packed {
        logic                       fbad;
        logic                       fneg;
        logic [2:0]                 csgn;
        logic                       jneg;
        logic                       jzero;
        logic                       ovf_inv;
        logic                       ovf_w;
        logic [Q_W-1:0]             qi;
        logic [Q_W-1:0]             qw;
        logic [WT_W-1:0]            wb;
        logic [J_W-1:0]             jabs;
        logic [LEN_W-1:0]           len;
        logic [2:0][LEN_W-1:0]      nrem;
        logic [2:0][NQ_W-1:0]       nq;
        logic [2:0]                 nbit;
        logic [J_W-1:0]             srem;
        logic [Q_W-1:0]             sq;
        logic                       ovf_sr;
        logic [1:0][PL_W-1:0]       pl;
        logic [LW_W-1:0]            lw;
        logic [2:0][PP_W-1:0]       pp;
        logic [WS_W-1:0]            ws;
    } t_back;

    // signed saturation of a magnitude to 32 bits
    function automatic logic [OUT_W-1:0] sat32(input logic neg, input logic ovf,
                                               input logic [Q_W-1:0] mag);
        logic [OUT_W-1:0] m;
        m = {1'b0, mag};
        if (ovf) begin
            sat32 = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sat32 = neg ? (~m + 32'd1) : m;
        end
    endfunction

endpackage

// File: src/hex_face_geometric_factors.sv
// Hex face metric terms: fixed-point Jacobian, normal, surface and weighted factors.
//
// channel  | dir | handshake                          | payload
// s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready  | tdata derivatives+weights, tuser face
// m_axis   | out | o_m_axis_tvalid / i_m_axis_tready  | tdata normal+factors, tuser degenerate
// cfg      | in  | i_cfg_wr_en                        | i_cfg_wr_data corner weight
//
// One item per cycle while the output is not stalled.
// The pipeline is F1 to F7, the 48 root stages, stage L, the 31 quotient stages and the output register.
// Reset clears the valid chain and loads the corner weight with 1.0.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module hex_face_geometric_factors (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // dx_dr dx_ds dx_dt dy_dr dy_ds dy_dt dz_dr dz_ds dz_dt weight_a weight_b
    input  logic [hfgf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // face
    input  logic [hfgf_pkg::FACE_W-1:0]         i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // normal_x normal_y normal_z surface_jacobian inv_volume_jacobian
    // weighted_inv_jacobian weighted_surface_jacobian size_ratio
    output logic [hfgf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // degenerate
    output logic                                o_m_axis_tuser,
    input  logic                                i_cfg_wr_en,
    input  logic [hfgf_pkg::WT_W-1:0]           i_cfg_wr_data
);

    localparam int unsigned JW  = hfgf_pkg::J_W;
    localparam int unsigned DW  = hfgf_pkg::D2_W;
    localparam int unsigned QW  = hfgf_pkg::Q_W;
    localparam int unsigned LW  = hfgf_pkg::LEN_W;
    localparam int unsigned REM_W_L = hfgf_pkg::REM_W + 2;

    logic                           w_en;
    logic [hfgf_pkg::LAT-1:0]       r_vld;
    logic [hfgf_pkg::WT_W-1:0]      r_cw;

    assign w_en            = !r_vld[hfgf_pkg::LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[hfgf_pkg::LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw  <= hfgf_pkg::CW_RESET;
            r_vld <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cw <= i_cfg_wr_data;
            end
            if (w_en) begin
                r_vld <= {r_vld[hfgf_pkg::LAT-2:0], i_s_axis_tvalid};
            end
        end
    end

    // ---------------- F1: 18 products ----------------
    logic signed [hfgf_pkg::D_W-1:0]    w_x [9];
    logic signed [hfgf_pkg::PROD_W-1:0] r1_prod [18];
    logic signed [hfgf_pkg::D_W-1:0]    r1_x [3];
    logic [hfgf_pkg::FACE_W-1:0]        r1_face;
    logic [hfgf_pkg::WT_W-1:0]          r1_wa, r1_wb;

    for (genvar i = 0; i < 9; i++) begin : g_in
        assign w_x[i] = $signed(i_s_axis_tdata[i*hfgf_pkg::D_W +: hfgf_pkg::D_W]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int p = 0; p < 18; p++) begin
                r1_prod[p] <= w_x[hfgf_pkg::CO_A[p]] * w_x[hfgf_pkg::CO_B[p]];
            end
            r1_x[0] <= w_x[0];
            r1_x[1] <= w_x[3];
            r1_x[2] <= w_x[6];
            r1_face <= i_s_axis_tuser;
            r1_wa   <= i_s_axis_tdata[288 +: hfgf_pkg::WT_W];
            r1_wb   <= i_s_axis_tdata[306 +: hfgf_pkg::WT_W];
        end
    end

    // ---------------- F2: cofactors ----------------
    logic signed [hfgf_pkg::COF_W-1:0]  r2_cof [9];
    logic signed [hfgf_pkg::D_W-1:0]    r2_x [3];
    logic [hfgf_pkg::FACE_W-1:0]        r2_face;
    logic [hfgf_pkg::WT_W-1:0]          r2_wa, r2_wb;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 9; c++) begin
                r2_cof[c] <= hfgf_pkg::COF_W'(r1_prod[2*c]) - hfgf_pkg::COF_W'(r1_prod[2*c+1]);
            end
            r2_x    <= r1_x;
            r2_face <= r1_face;
            r2_wa   <= r1_wa;
            r2_wb   <= r1_wb;
        end
    end

    // ---------------- F3: J partial products, row select ----------------
    logic signed [63:0]     r3_jhi [3];
    logic signed [65:0]     r3_jlo [3];
    hfgf_pkg::t_node        r3_nd;
    hfgf_pkg::t_node        n3_nd;
    logic [1:0]             w_sel;

    always_comb begin
        logic signed [48:0] c;
        logic [48:0]        a;
        n3_nd      = '0;
        w_sel      = 2'd0;
        n3_nd.fbad = 1'b0;
        n3_nd.fneg = 1'b0;
        case (r2_face)
            hfgf_pkg::FACE_NEG_T: begin w_sel = 2'd2; n3_nd.fneg = 1'b1; end
            hfgf_pkg::FACE_NEG_S: begin w_sel = 2'd1; n3_nd.fneg = 1'b1; end
            hfgf_pkg::FACE_POS_R: begin w_sel = 2'd0; n3_nd.fneg = 1'b0; end
            hfgf_pkg::FACE_POS_S: begin w_sel = 2'd1; n3_nd.fneg = 1'b0; end
            hfgf_pkg::FACE_NEG_R: begin w_sel = 2'd0; n3_nd.fneg = 1'b1; end
            hfgf_pkg::FACE_POS_T: begin w_sel = 2'd2; n3_nd.fneg = 1'b0; end
            default:              begin w_sel = 2'd0; n3_nd.fbad = 1'b1; end
        endcase
        for (int k = 0; k < 3; k++) begin
            c = $signed(r2_cof[3*w_sel + k][64:16]);
            a = c[48] ? 49'(-c) : c;
            n3_nd.csgn[k] = c[48];
            n3_nd.mag[k]  = a[hfgf_pkg::MAG_W-1:0];
        end
        n3_nd.wa = r2_wa;
        n3_nd.wb = r2_wb;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r3_jhi[j] <= r2_x[j] * $signed(r2_cof[j][64:33]);
                r3_jlo[j] <= r2_x[j] * $signed({1'b0, r2_cof[j][32:0]});
            end
            r3_nd <= n3_nd;
        end
    end

    // ---------------- F4: J sum, square partials ----------------
    logic signed [JW-1:0]       r4_j;
    logic [47:0]                r4_hh [3];
    logic [47:0]                r4_hl [3];
    logic [47:0]                r4_ll [3];
    hfgf_pkg::t_node            r4_nd;
    logic signed [JW-1:0]       n4_j;

    always_comb begin
        n4_j = '0;
        for (int j = 0; j < 3; j++) begin
            n4_j = n4_j + (JW'(r3_jhi[j]) <<< 33) + JW'(r3_jlo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_j <= n4_j;
            for (int k = 0; k < 3; k++) begin
                r4_hh[k] <= r3_nd.mag[k][47:24] * r3_nd.mag[k][47:24];
                r4_hl[k] <= r3_nd.mag[k][47:24] * r3_nd.mag[k][23:0];
                r4_ll[k] <= r3_nd.mag[k][23:0]  * r3_nd.mag[k][23:0];
            end
            r4_nd <= r3_nd;
        end
    end

    // ---------------- F5: |J|, sum of squares ----------------
    logic [JW-1:0]                  r5_jabs;
    logic                           r5_jneg;
    logic [hfgf_pkg::SQ_W-1:0]      r5_sumsq;
    hfgf_pkg::t_node                r5_nd;
    logic [hfgf_pkg::SQ_W-1:0]      n5_sumsq;

    always_comb begin
        n5_sumsq = '0;
        for (int k = 0; k < 3; k++) begin
            n5_sumsq = n5_sumsq + (hfgf_pkg::SQ_W'(r4_hh[k]) << 48)
                     + (hfgf_pkg::SQ_W'(r4_hl[k]) << 25) + hfgf_pkg::SQ_W'(r4_ll[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_jabs  <= r4_j[JW-1] ? JW'(-r4_j) : r4_j;
            r5_jneg  <= r4_j[JW-1];
            r5_sumsq <= n5_sumsq;
            r5_nd    <= r4_nd;
        end
    end

    // ---------------- F6: |J| * corner weight partials ----------------
    logic [hfgf_pkg::CWP_W-1:0]     r6_cwp [hfgf_pkg::CHK_N];
    logic [JW-1:0]                  r6_jabs;
    logic                           r6_jneg;
    logic                           r6_jzero;
    logic                           r6_ovf_inv;
    logic [hfgf_pkg::SQ_W-1:0]      r6_sumsq;
    hfgf_pkg::t_node                r6_nd;
    logic [hfgf_pkg::CHK_W*hfgf_pkg::CHK_N-1:0] w_jpad;

    assign w_jpad = (hfgf_pkg::CHK_W*hfgf_pkg::CHK_N)'(r5_jabs);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < hfgf_pkg::CHK_N; i++) begin
                r6_cwp[i] <= w_jpad[i*hfgf_pkg::CHK_W +: hfgf_pkg::CHK_W] * r_cw;
            end
            r6_jabs    <= r5_jabs;
            r6_jneg    <= r5_jneg;
            r6_jzero   <= (r5_jabs == '0);
            // 2^64/|J| reaches 2^31 once |J| <= 2^33
            r6_ovf_inv <= (r5_jabs <= (JW'(1) << 33));
            r6_sumsq   <= r5_sumsq;
            r6_nd      <= r5_nd;
        end
    end

    // ---------------- F7: divisor sum, stage setup ----------------
    hfgf_pkg::t_mid r_mid [hfgf_pkg::SQ_STEPS+1];
    hfgf_pkg::t_mid n7_mid;

    always_comb begin
        logic [DW-1:0] d2;
        d2 = '0;
        for (int i = 0; i < hfgf_pkg::CHK_N; i++) begin
            d2 = d2 + (DW'(r6_cwp[i]) << (i*hfgf_pkg::CHK_W));
        end
        n7_mid         = '0;
        n7_mid.nd      = r6_nd;
        n7_mid.jneg    = r6_jneg;
        n7_mid.jzero   = r6_jzero;
        n7_mid.jabs    = r6_jabs;
        n7_mid.d2      = d2;
        n7_mid.ovf_inv = r6_ovf_inv;
        n7_mid.ovf_w   = (d2 <= (DW'(1) << 49));   // also covers a zero weight
        n7_mid.n       = r6_sumsq;
        n7_mid.ri      = JW'(1) << 33;             // 2^64 >> 31
        n7_mid.rw      = DW'(1) << 49;             // 2^80 >> 31
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mid[0] <= n7_mid;
        end
    end

    // ---------------- root stages, with the two J quotients alongside ----------------
    for (genvar s = 0; s < hfgf_pkg::SQ_STEPS; s++) begin : g_sq
        hfgf_pkg::t_mid n_mid;

        always_comb begin
            logic [REM_W_L-1:0] t;
            logic [REM_W_L-1:0] trial;
            logic [JW:0]        ti;
            logic [DW:0]        tw;
            n_mid = r_mid[s];
            t     = {r_mid[s].rem, r_mid[s].n[hfgf_pkg::SQ_W-1 -: 2]};
            trial = {2'b00, r_mid[s].root, 2'b01};
            n_mid.n = {r_mid[s].n[hfgf_pkg::SQ_W-3:0], 2'b00};
            if (t >= trial) begin
                n_mid.rem  = hfgf_pkg::REM_W'(t - trial);
                n_mid.root = {r_mid[s].root[LW-2:0], 1'b1};
            end else begin
                n_mid.rem  = hfgf_pkg::REM_W'(t);
                n_mid.root = {r_mid[s].root[LW-2:0], 1'b0};
            end
            ti = {r_mid[s].ri, 1'b0};
            tw = {r_mid[s].rw, 1'b0};
            if (s < QW) begin
                if (ti >= {1'b0, r_mid[s].jabs}) begin
                    n_mid.ri = JW'(ti - {1'b0, r_mid[s].jabs});
                    n_mid.qi = {r_mid[s].qi[QW-2:0], 1'b1};
                end else begin
                    n_mid.ri = JW'(ti);
                    n_mid.qi = {r_mid[s].qi[QW-2:0], 1'b0};
                end
                if (tw >= {1'b0, r_mid[s].d2}) begin
                    n_mid.rw = DW'(tw - {1'b0, r_mid[s].d2});
                    n_mid.qw = {r_mid[s].qw[QW-2:0], 1'b1};
                end else begin
                    n_mid.rw = DW'(tw);
                    n_mid.qw = {r_mid[s].qw[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_mid[s+1] <= n_mid;
            end
        end
    end

    // ---------------- L: length known, set up normal and ratio quotients ----------------
    hfgf_pkg::t_back r_bk [hfgf_pkg::BK_STEPS+1];
    hfgf_pkg::t_back n_bk0;

    always_comb begin
        hfgf_pkg::t_mid m;
        m              = r_mid[hfgf_pkg::SQ_STEPS];
        n_bk0          = '0;
        n_bk0.fbad     = m.nd.fbad;
        n_bk0.fneg     = m.nd.fneg;
        n_bk0.csgn     = m.nd.csgn;
        n_bk0.jneg     = m.jneg;
        n_bk0.jzero    = m.jzero;
        n_bk0.ovf_inv  = m.ovf_inv;
        n_bk0.ovf_w    = m.ovf_w;
        n_bk0.qi       = m.qi;
        n_bk0.qw       = m.qw;
        n_bk0.wb       = m.nd.wb;
        n_bk0.jabs     = m.jabs;
        n_bk0.len      = m.root;
        for (int k = 0; k < 3; k++) begin
            n_bk0.nrem[k] = LW'(m.nd.mag[k] >> 1);
            n_bk0.nbit[k] = m.nd.mag[k][0];
        end
        n_bk0.srem     = JW'({m.root, 17'd0});
        // len * 2^48 / |J| reaches 2^31 once len * 2^17 >= |J|
        n_bk0.ovf_sr   = (JW'({m.root, 17'd0}) >= m.jabs);
        n_bk0.pl[0]    = m.root[23:0]  * m.nd.wa;
        n_bk0.pl[1]    = m.root[47:24] * m.nd.wa;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bk[0] <= n_bk0;
        end
    end

    // ---------------- quotient stages ----------------
    for (genvar b = 0; b < hfgf_pkg::BK_STEPS; b++) begin : g_bk
        hfgf_pkg::t_back n_bk;

        always_comb begin
            logic [LW:0]                    tn;
            logic [JW:0]                    ts;
            logic [hfgf_pkg::WS_SUM_W-1:0]  wsum;
            n_bk = r_bk[b];
            wsum = '0;
            tn   = '0;
            if (b < hfgf_pkg::NQ_W) begin
                for (int k = 0; k < 3; k++) begin
                    tn = {r_bk[b].nrem[k], (b == 0) ? r_bk[b].nbit[k] : 1'b0};
                    if (tn >= {1'b0, r_bk[b].len}) begin
                        n_bk.nrem[k] = LW'(tn - {1'b0, r_bk[b].len});
                        n_bk.nq[k]   = {r_bk[b].nq[k][hfgf_pkg::NQ_W-2:0], 1'b1};
                    end else begin
                        n_bk.nrem[k] = LW'(tn);
                        n_bk.nq[k]   = {r_bk[b].nq[k][hfgf_pkg::NQ_W-2:0], 1'b0};
                    end
                end
            end
            ts = {r_bk[b].srem, 1'b0};
            if (ts >= {1'b0, r_bk[b].jabs}) begin
                n_bk.srem = JW'(ts - {1'b0, r_bk[b].jabs});
                n_bk.sq   = {r_bk[b].sq[QW-2:0], 1'b1};
            end else begin
                n_bk.srem = JW'(ts);
                n_bk.sq   = {r_bk[b].sq[QW-2:0], 1'b0};
            end
            // weighted surface: len*wa, then *wb, then sum and drop 32 bits
            if (b == 0) begin
                n_bk.lw = hfgf_pkg::LW_W'(r_bk[b].pl[0])
                        + (hfgf_pkg::LW_W'(r_bk[b].pl[1]) << 24);
            end
            if (b == 1) begin
                for (int i = 0; i < 3; i++) begin
                    n_bk.pp[i] = r_bk[b].lw[i*hfgf_pkg::LW_CH +: hfgf_pkg::LW_CH] * r_bk[b].wb;
                end
            end
            if (b == 2) begin
                wsum = hfgf_pkg::WS_SUM_W'(r_bk[b].pp[0])
                     + (hfgf_pkg::WS_SUM_W'(r_bk[b].pp[1]) << hfgf_pkg::LW_CH)
                     + (hfgf_pkg::WS_SUM_W'(r_bk[b].pp[2]) << (2*hfgf_pkg::LW_CH));
                n_bk.ws = wsum[hfgf_pkg::WS_SUM_W-1:32];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_bk[b+1] <= n_bk;
            end
        end
    end

    // ---------------- output register ----------------
    logic [hfgf_pkg::NRM_W-1:0]   r_o_nrm [3];
    logic [hfgf_pkg::OUT_W-1:0]   r_o_sj, r_o_inv, r_o_winv, r_o_wsj, r_o_ratio;
    logic                         r_o_deg;

    always_ff @(posedge i_clk) begin
        hfgf_pkg::t_back f;
        logic            deg;
        logic            nn;
        f   = r_bk[hfgf_pkg::BK_STEPS];
        deg = f.fbad || f.jzero || (f.len == '0);
        if (w_en) begin
            r_o_deg <= deg;
            for (int k = 0; k < 3; k++) begin
                nn = f.fneg ^ f.jneg ^ f.csgn[k];
                if (deg) begin
                    r_o_nrm[k] <= '0;
                end else begin
                    r_o_nrm[k] <= nn ? hfgf_pkg::NRM_W'(-{1'b0, f.nq[k]}) : {1'b0, f.nq[k]};
                end
            end
            if (deg) begin
                r_o_sj    <= 32'h7FFF_FFFF;
                r_o_inv   <= 32'h7FFF_FFFF;
                r_o_winv  <= 32'h7FFF_FFFF;
                r_o_wsj   <= 32'h7FFF_FFFF;
                r_o_ratio <= 32'h7FFF_FFFF;
            end else begin
                r_o_sj    <= hfgf_pkg::sat32(f.jneg, f.len[LW-1:QW] != '0, f.len[QW-1:0]);
                r_o_inv   <= hfgf_pkg::sat32(f.jneg, f.ovf_inv, f.qi);
                r_o_winv  <= hfgf_pkg::sat32(f.jneg, f.ovf_w, f.qw);
                r_o_wsj   <= hfgf_pkg::sat32(f.jneg, f.ws[hfgf_pkg::WS_W-1:QW] != '0,
                                             f.ws[QW-1:0]);
                r_o_ratio <= hfgf_pkg::sat32(1'b0, f.ovf_sr, f.sq);
            end
        end
    end

    assign o_m_axis_tdata = {2'b00, r_o_ratio, r_o_wsj, r_o_winv, r_o_inv, r_o_sj,
                             r_o_nrm[2], r_o_nrm[1], r_o_nrm[0]};
    assign o_m_axis_tuser = r_o_deg;

    // ---------------- assertions ----------------
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid chain moved during a stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");

    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
            ($signed(r_o_nrm[0]) <= 18'sd65536 && $signed(r_o_nrm[0]) >= -18'sd65536 &&
             $signed(r_o_nrm[1]) <= 18'sd65536 && $signed(r_o_nrm[1]) >= -18'sd65536 &&
             $signed(r_o_nrm[2]) <= 18'sd65536 && $signed(r_o_nrm[2]) >= -18'sd65536))
        else $error("unit normal component out of range");

endmodule
